// ----- src/sync_crc8_packet_deframer_unit_defines.svh -----
// Assertion macros for the sync/CRC-8 packet deframer checker.
// Included by the checker file only; relies on clk and rst_n in scope.
`ifndef SYNC_CRC8_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_CRC8_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SCPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/scpd_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the deframer.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package scpd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_CRC_ERR = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_READY_MASK    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [1:0] REG_SYNC_FIRST    = 2'd2;
    localparam logic [1:0] REG_SYNC_SECOND   = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_READY_MASK    = 16'h001D;
    localparam logic [7:0]  RST_TIMEOUT_LIMIT = 8'd10;
    localparam logic [7:0]  RST_SYNC_FIRST    = 8'h34;
    localparam logic [7:0]  RST_SYNC_SECOND   = 8'h12;

    // CRC-8, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [7:0] TIMEOUT_MAX   = 8'hFF;
    localparam logic [3:0] PRESCALE_LAST = 4'hF;

    // Receive hunt state
    typedef enum logic [1:0] {
        HS_FIRST,
        HS_SECOND,
        HS_COLLECT,
        HS_LOCKED
    } scpd_hunt_t;

    // Controller state
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SINGLE,
        CS_READ,
        CS_PAYLOAD
    } scpd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic cnt_inc;
    } scpd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic frame_end;
        logic crc_ok;
        logic cnt_last;
    } scpd_sts_t;

    // One byte through the CRC-8 register
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/sync_crc8_packet_deframer_unit.sv -----
// Top level of the sync-word CRC-8 packet deframer.
// Depends on scpd_pkg, scpd_ctrl and scpd_datapath.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    cmd, rx_byte
//  out      source     out_valid / out_stall  kind .. frame_count
//  cfg      sink       cfg_we                 cfg_addr, cfg_wdata
//
// A byte that yields no result is not stalled; the next one is taken at once.
// A tick or CRC error is taken in, then its one result is sent from CS_SINGLE.
// A good frame drains PAYLOAD_BYTES results, each a memory read (CS_READ), then
// the transfer (CS_PAYLOAD), before the next byte is taken.
// Input is stalled while a result waits; an output stall holds the result.
// Reset is asynchronous; no clearing pass follows it.
`default_nettype none

module sync_crc8_packet_deframer_unit #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [5:0]       byte_offset,
    output logic [3:0]       packet_index,
    output logic [3:0]       packet_id,
    output logic             last,
    output logic [15:0]      updated_bits,
    output logic             timeout_flag,
    output logic             diag_request,
    output logic             ready_res,
    output logic [15:0]      frame_count
);
    import scpd_pkg::*;

    scpd_cmd_t ctl_cmd;
    scpd_sts_t ctl_sts;

    // Sequence transfers
    scpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl_sts   (ctl_sts),
        .ctl_cmd   (ctl_cmd)
    );

    // Frame state, payload store and result fields
    scpd_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .ctl_cmd      (ctl_cmd),
        .ctl_sts      (ctl_sts),
        .kind         (kind),
        .payload_byte (payload_byte),
        .byte_offset  (byte_offset),
        .packet_index (packet_index),
        .packet_id    (packet_id),
        .last         (last),
        .updated_bits (updated_bits),
        .timeout_flag (timeout_flag),
        .diag_request (diag_request),
        .ready_res    (ready_res),
        .frame_count  (frame_count)
    );

endmodule

`default_nettype wire

// ----- src/scpd_ctrl.sv -----
// Controller state machine: input acceptance and result sequencing.
// Depends on scpd_pkg for state, command and status types.
`default_nettype none

module scpd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire scpd_pkg::scpd_sts_t ctl_sts,
    output scpd_pkg::scpd_cmd_t    ctl_cmd
);
    import scpd_pkg::*;

    scpd_state_t state_reg;
    scpd_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= CS_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Decide next state and issue datapath commands
    always_comb begin
        state_next      = state_reg;
        ctl_cmd         = '0;
        in_stall        = 1'b1;
        out_valid       = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                in_stall       = 1'b0;
                ctl_cmd.accept = in_valid;
                if (in_valid) begin
                    if (ctl_sts.is_tick || (ctl_sts.frame_end && !ctl_sts.crc_ok)) begin
                        state_next = CS_SINGLE;
                    end
                    else if (ctl_sts.frame_end) begin
                        state_next = CS_READ;
                    end
                end
            end
            CS_SINGLE: begin
                out_valid = 1'b1;
                if (!out_stall) begin
                    state_next = CS_IDLE;
                end
            end
            CS_READ: begin
                ctl_cmd.rd_en = 1'b1;
                state_next    = CS_PAYLOAD;
            end
            CS_PAYLOAD: begin
                out_valid = 1'b1;
                if (!out_stall) begin
                    if (ctl_sts.cnt_last) begin
                        state_next = CS_IDLE;
                    end
                    else begin
                        ctl_cmd.cnt_inc = 1'b1;
                        state_next      = CS_READ;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/scpd_datapath.sv -----
// Datapath: config registers, hunt/CRC state, payload memory, timeout and
// result fields. Depends on scpd_pkg; driven by scpd_ctrl commands.
`default_nettype none

module scpd_datapath #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                cmd,
    input  wire logic [7:0]          rx_byte,
    input  wire scpd_pkg::scpd_cmd_t ctl_cmd,
    output scpd_pkg::scpd_sts_t      ctl_sts,
    output logic [1:0]               kind,
    output logic [7:0]               payload_byte,
    output logic [5:0]               byte_offset,
    output logic [3:0]               packet_index,
    output logic [3:0]               packet_id,
    output logic                     last,
    output logic [15:0]              updated_bits,
    output logic                     timeout_flag,
    output logic                     diag_request,
    output logic                     ready_res,
    output logic [15:0]              frame_count
);
    import scpd_pkg::*;

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int POS_W = $clog2(PAYLOAD_BYTES + 4);

    localparam logic [POS_W-1:0] POS_PAY   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_INDEX = POS_W'(PAYLOAD_BYTES + 2);
    localparam logic [POS_W-1:0] POS_CRC   = POS_W'(PAYLOAD_BYTES + 3);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(PAYLOAD_BYTES - 1);

    // Configuration
    logic [15:0] ready_mask_reg;
    logic [7:0]  timeout_limit_reg;
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;

    // Receive and timeout state
    scpd_hunt_t       hunt_reg, hunt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       index_reg, index_next;
    logic [15:0]      updated_reg, updated_next;
    logic [7:0]       tcount_reg, tcount_next;
    logic             tflag_reg, tflag_next;
    logic [3:0]       prescale_reg, prescale_next;
    logic [15:0]      frames_reg, frames_next;

    // Result staging
    logic [1:0]       kind_reg, kind_next;
    logic             diag_reg, diag_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       rd_data_reg;

    // Payload store
    logic [7:0] mem [PAYLOAD_BYTES];

    logic             in_frame;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       crc_run;
    logic [7:0]       crc_fresh;
    logic [7:0]       tcount_inc;

    assign in_frame   = (hunt_reg == HS_COLLECT) || (hunt_reg == HS_LOCKED);
    assign crc_run    = crc8_next(crc_reg, rx_byte);
    assign crc_fresh  = crc8_next(CRC_INIT, rx_byte);
    assign tcount_inc = (tcount_reg == TIMEOUT_MAX) ? TIMEOUT_MAX : tcount_reg + 8'd1;
    assign wr_en      = ctl_cmd.accept && !cmd && in_frame
                        && (pos_reg >= POS_PAY) && (pos_reg < POS_INDEX);
    assign wr_addr    = IDX_W'(pos_reg - POS_PAY);

    // Report status to the controller
    always_comb begin
        ctl_sts.is_tick   = cmd;
        ctl_sts.frame_end = !cmd && in_frame && (pos_reg == POS_CRC);
        ctl_sts.crc_ok    = (crc_reg == rx_byte);
        ctl_sts.cnt_last  = (cnt_reg == IDX_LAST);
    end

    // Process one accepted byte or tick; advance the drain counter
    always_comb begin
        hunt_next     = hunt_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        index_next    = index_reg;
        updated_next  = updated_reg;
        tcount_next   = tcount_reg;
        tflag_next    = tflag_reg;
        prescale_next = prescale_reg;
        frames_next   = frames_reg;
        kind_next     = kind_reg;
        diag_next     = diag_reg;
        cnt_next      = cnt_reg;
        if (ctl_cmd.accept) begin
            cnt_next = '0;
            if (cmd) begin
                prescale_next = prescale_reg + 4'd1;
                kind_next     = KIND_TICK;
                diag_next     = (prescale_reg == PRESCALE_LAST);
                if (prescale_reg == PRESCALE_LAST) begin
                    tcount_next = tcount_inc;
                    if (tcount_inc > timeout_limit_reg) begin
                        if (!tflag_reg) begin
                            tflag_next   = 1'b1;
                            updated_next = '0;
                        end
                    end
                    else begin
                        tflag_next = 1'b0;
                    end
                end
            end
            else begin
                case (hunt_reg)
                    HS_FIRST: begin
                        if (rx_byte == sync_first_reg) begin
                            crc_next  = crc_fresh;
                            hunt_next = HS_SECOND;
                        end
                    end
                    HS_SECOND: begin
                        if (rx_byte == sync_second_reg) begin
                            crc_next  = crc_run;
                            hunt_next = HS_COLLECT;
                            pos_next  = POS_PAY;
                        end
                        else if (rx_byte == sync_first_reg) begin
                            crc_next = crc_fresh;
                        end
                        else begin
                            hunt_next = HS_FIRST;
                        end
                    end
                    default: begin
                        if (pos_reg < POS_CRC) begin
                            if (pos_reg == POS_INDEX) begin
                                index_next = rx_byte;
                            end
                            crc_next = crc_run;
                            pos_next = pos_reg + POS_W'(1);
                        end
                        else if (crc_reg != rx_byte) begin
                            // Bad frame: drop lock and hunt again
                            hunt_next = HS_FIRST;
                            pos_next  = '0;
                            crc_next  = CRC_INIT;
                            kind_next = KIND_CRC_ERR;
                            diag_next = 1'b0;
                        end
                        else begin
                            // Good frame: stay locked on the next one
                            tcount_next  = '0;
                            frames_next  = frames_reg + 16'd1;
                            updated_next = updated_reg | (16'd1 << index_reg[3:0]);
                            hunt_next    = HS_LOCKED;
                            pos_next     = '0;
                            crc_next     = CRC_INIT;
                            kind_next    = KIND_PAYLOAD;
                            diag_next    = 1'b0;
                        end
                    end
                endcase
            end
        end
        if (ctl_cmd.cnt_inc) begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    // Hold configuration and control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ready_mask_reg    <= RST_READY_MASK;
            timeout_limit_reg <= RST_TIMEOUT_LIMIT;
            sync_first_reg    <= RST_SYNC_FIRST;
            sync_second_reg   <= RST_SYNC_SECOND;
            hunt_reg          <= HS_FIRST;
            pos_reg           <= '0;
            crc_reg           <= CRC_INIT;
            index_reg         <= '0;
            updated_reg       <= '0;
            tcount_reg        <= '0;
            tflag_reg         <= 1'b0;
            prescale_reg      <= '0;
            frames_reg        <= '0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_READY_MASK:    ready_mask_reg    <= cfg_wdata;
                    REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata[7:0];
                    REG_SYNC_FIRST:    sync_first_reg    <= cfg_wdata[7:0];
                    REG_SYNC_SECOND:   sync_second_reg   <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            hunt_reg     <= hunt_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            index_reg    <= index_next;
            updated_reg  <= updated_next;
            tcount_reg   <= tcount_next;
            tflag_reg    <= tflag_next;
            prescale_reg <= prescale_next;
            frames_reg   <= frames_next;
        end
    end

    // Hold result staging
    always_ff @(posedge clk) begin
        kind_reg <= kind_next;
        diag_reg <= diag_next;
        cnt_reg  <= cnt_next;
    end

    // Write payload bytes, read one for the drain
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= rx_byte;
        end
        if (ctl_cmd.rd_en) begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    // Drive result fields from held state
    assign kind         = kind_reg;
    assign payload_byte = (kind_reg == KIND_PAYLOAD) ? rd_data_reg : 8'd0;
    assign byte_offset  = (kind_reg == KIND_PAYLOAD) ? 6'(cnt_reg) : 6'd0;
    assign packet_index = index_reg[3:0];
    assign packet_id    = index_reg[7:4];
    assign last         = (kind_reg != KIND_PAYLOAD) || (cnt_reg == IDX_LAST);
    assign updated_bits = updated_reg;
    assign timeout_flag = tflag_reg;
    assign diag_request = diag_reg;
    assign ready_res    = ((updated_reg & ready_mask_reg) == ready_mask_reg);
    assign frame_count  = frames_reg;

endmodule

`default_nettype wire

// ----- src/scpd_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
// Depends on scpd_pkg and sync_crc8_packet_deframer_unit_defines.svh.
`default_nettype none
`include "sync_crc8_packet_deframer_unit_defines.svh"

module scpd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] payload_byte,
    input wire logic [5:0] byte_offset,
    input wire logic       last,
    input wire logic       diag_request
);
    import scpd_pkg::*;

    logic        single_res;
    logic        diag_res;
    logic        res_held;
    logic [15:0] res_view;

    // Name the conditions the assertions look at
    assign single_res = out_valid && (kind != KIND_PAYLOAD);
    assign diag_res   = out_valid && diag_request;
    assign res_held   = out_valid && out_stall;
    assign res_view   = {kind, payload_byte, byte_offset};

    // Input is never taken while a result is pending
    `SCPD_ASSERT_SAME(a_no_in_while_out, out_valid, in_stall, "input taken while result pending")

    // Single results always close their run
    `SCPD_ASSERT_SAME(a_single_last, single_res, last, "single result without last")

    // Only tick results may request diagnostics
    `SCPD_ASSERT_SAME(a_diag_tick, diag_res, kind == KIND_TICK, "diag request on non-tick result")

    // A stalled result holds
    `SCPD_ASSERT_NEXT(a_hold, res_held, out_valid && $stable(res_view), "stalled result changed")

endmodule

bind sync_crc8_packet_deframer_unit scpd_checker u_scpd_checker (.*);

`default_nettype wire
